>>> hw/rtl/fec_block_erasure_tracker_macros.svh
// ----------------------------------------------------------------------------
// FEC block erasure tracker assertion macros
// Concurrent check wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FEC_BLOCK_ERASURE_TRACKER_MACROS_SVH
`define FEC_BLOCK_ERASURE_TRACKER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define FBET_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define FBET_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FBET_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define FBET_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> hw/rtl/fbet_pkg.sv
// ----------------------------------------------------------------------------
// fbet_pkg
// Types, constants and slot layout helpers for the FEC block erasure tracker.
// ----------------------------------------------------------------------------
package fbet_pkg;

    localparam int MaxSlots  = 32;
    localparam int SlotW     = $clog2(MaxSlots);
    localparam int SeqW      = 32;
    localparam int DivCntW   = $clog2(SeqW);
    localparam int CntW      = 5;     // holds 0..16
    localparam int PairW     = 4;
    localparam int MaxKind   = 16;    // max data or FEC slots per block
    localparam int CfgW      = 16;
    localparam int CfgIdxW   = 2;

    localparam logic [CfgIdxW-1:0] RegDataSlots     = 2'd0;
    localparam logic [CfgIdxW-1:0] RegFecSlots      = 2'd1;
    localparam logic [CfgIdxW-1:0] RegRestartWindow = 2'd2;

    typedef struct packed {
        logic [SeqW-1:0] seq_num;
        logic            packet_crc_ok;
    } in_t;

    typedef struct packed {
        logic             block_closed;
        logic [SeqW-1:0]  closed_block_number;
        logic             pair_valid;
        logic [PairW-1:0] erased_data_index;
        logic [PairW-1:0] fec_index;
        logic [CntW-1:0]  data_missing_count;
        logic [CntW-1:0]  fec_missing_count;
        logic             recon_failed;
        logic             restart_seen;
        logic             packet_stored;
        logic             last;
    } out_t;

    function automatic logic [CntW-1:0] eff_data(input logic [CntW-1:0] raw);
        logic [CntW-1:0] d;
        d = raw;
        if (d == '0)
            d = CntW'(1);
        if (d > CntW'(MaxKind))
            d = CntW'(MaxKind);
        if (int'(d) > MaxSlots)
            d = CntW'(MaxSlots);
        return d;
    endfunction

    function automatic logic [CntW-1:0] eff_fec(input logic [CntW-1:0] raw,
                                                 input logic [CntW-1:0] d);
        logic [CntW-1:0] f;
        f = raw;
        if (f > CntW'(MaxKind))
            f = CntW'(MaxKind);
        if (int'(d) + int'(f) > MaxSlots)
            f = CntW'(MaxSlots - int'(d));
        return f;
    endfunction

    // data k sits at k + min(k, f)
    function automatic logic [SlotW-1:0] data_pos(input logic [CntW-1:0] k,
                                                  input logic [CntW-1:0] f);
        logic [CntW:0] m;
        m = (k < f) ? {1'b0, k} : {1'b0, f};
        return SlotW'({1'b0, k} + m);
    endfunction

    // FEC k sits at k + min(k + 1, d)
    function automatic logic [SlotW-1:0] fec_pos(input logic [CntW-1:0] k,
                                                 input logic [CntW-1:0] d);
        logic [CntW:0] k1;
        logic [CntW:0] m;
        k1 = {1'b0, k} + (CntW+1)'(1);
        m  = (k1 < {1'b0, d}) ? k1 : {1'b0, d};
        return SlotW'({1'b0, k} + m);
    endfunction

endpackage

>>> hw/rtl/fec_block_erasure_tracker.sv
// ----------------------------------------------------------------------------
// fec_block_erasure_tracker
// Tracks received slots of one FEC block; on block close reports erasure
// substitution pairs, missing counts and reconstruction status.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+----------------------------
//  in       | input     | in_valid / in_ready | in_data  (fbet_pkg::in_t)
//  out      | output    | out_valid/out_ready | out_data (fbet_pkg::out_t)
//  cfg      | input     | cfg_we              | cfg_index, cfg_data
//
// Each packet passes through the shared restoring divider (block number and
// slot), during which the pairing walk and missing counts run over the slot
// bits, then a decide and an apply state, then one result at a time is
// loaded into the output register.
// Reset clears all slot bits at once; no clearing pass.
// in_ready is low while a packet is in work; out stalls hold the emit sequence.
`include "fec_block_erasure_tracker_macros.svh"

module fec_block_erasure_tracker
    import fbet_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_t                in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output out_t               out_data,
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgW-1:0]    cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIV    = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_APPLY  = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0]          state_reg;

    logic [CntW-1:0]     data_slots_reg;
    logic [CntW-1:0]     fec_slots_reg;
    logic [CfgW-1:0]     restart_window_reg;

    logic                open_valid_reg;
    logic [SeqW-1:0]     open_block_reg;
    logic                high_valid_reg;
    logic [SeqW-1:0]     high_block_reg;
    logic [MaxSlots-1:0] rcv_reg;
    logic [MaxSlots-1:0] good_reg;
    logic [MaxSlots-1:0] rcv_next;
    logic [MaxSlots-1:0] good_next;

    logic [SeqW-1:0]     seq_reg;      // dividend, then quotient
    logic                ok_reg;
    logic [SlotW-1:0]    rem_reg;
    logic [DivCntW-1:0]  cnt_reg;

    logic [CntW-1:0]     di_reg;
    logic [CntW-1:0]     fi_reg;
    logic [CntW-1:0]     dmiss_reg;
    logic [CntW-1:0]     fmiss_reg;
    logic [CntW-1:0]     npairs_reg;
    logic [PairW-1:0]    pair_d_reg [MaxKind];
    logic [PairW-1:0]    pair_f_reg [MaxKind];

    logic                restart_reg;
    logic                take_reg;
    logic                close_reg;

    logic                res_stored_reg;
    logic [SeqW-1:0]     res_cnum_reg;
    logic [CntW-1:0]     emit_n_reg;
    logic [CntW-1:0]     emit_idx_reg;

    logic                out_valid_reg;
    out_t                out_data_reg;

    // ------------------------------------------------------------------
    logic [CntW-1:0]     eff_d;
    logic [CntW-1:0]     eff_f;
    logic [SlotW:0]      blk_size;

    assign eff_d    = eff_data(data_slots_reg);
    assign eff_f    = eff_fec(fec_slots_reg, eff_d);
    assign blk_size = (SlotW+1)'(eff_d) + (SlotW+1)'(eff_f);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // divider step
    logic [SlotW:0]      rem_sh;
    logic                q_bit;
    logic [SlotW:0]      rem_sub;

    assign rem_sh  = {rem_reg, seq_reg[SeqW-1]};
    assign q_bit   = (rem_sh >= blk_size);
    assign rem_sub = rem_sh - blk_size;

    // missing counts, one data and one FEC slot per cycle
    logic [CntW-1:0]     cnt_k;
    logic                cnt_on;
    logic                dmiss_hit;
    logic                fmiss_hit;

    assign cnt_k     = CntW'(cnt_reg);
    assign cnt_on    = (cnt_k < CntW'(MaxKind));
    assign dmiss_hit = cnt_on && (cnt_k < eff_d) && !rcv_reg[data_pos(cnt_k, eff_f)];
    assign fmiss_hit = cnt_on && (cnt_k < eff_f) && !rcv_reg[fec_pos(cnt_k, eff_d)];

    // pairing walk
    logic [SlotW-1:0]    wd_pos;
    logic [SlotW-1:0]    wf_pos;
    logic                walk_on;
    logic                d_good;

    assign wd_pos  = data_pos(di_reg, eff_f);
    assign wf_pos  = fec_pos(fi_reg, eff_d);
    assign walk_on = (di_reg < eff_d) && (fi_reg < eff_f);
    assign d_good  = rcv_reg[wd_pos] && good_reg[wd_pos];

    // decide
    logic [SeqW:0]       sum_rw;
    logic                restart_now;
    logic                newer_now;

    assign sum_rw      = {1'b0, seq_reg} + (SeqW+1)'(restart_window_reg);
    assign restart_now = high_valid_reg && (sum_rw < {1'b0, high_block_reg});
    assign newer_now   = !high_valid_reg || (seq_reg > high_block_reg);

    // apply
    logic                clear_now;
    logic                same_open;
    logic                store_now;

    assign clear_now = take_reg && (restart_reg || open_valid_reg);
    assign same_open = take_reg || (open_valid_reg && (open_block_reg == seq_reg));
    assign store_now = same_open && !(!clear_now && good_reg[rem_reg]);

    // slot bits after the apply cycle: clear first, then mark the packet
    always_comb
    begin
        rcv_next  = clear_now ? '0 : rcv_reg;
        good_next = clear_now ? '0 : good_reg;
        if (store_now)
        begin
            rcv_next[rem_reg]  = 1'b1;
            good_next[rem_reg] = ok_reg;
        end
    end

    // emit
    logic                emit_load;
    logic                emit_last;
    logic                emit_pv;

    assign emit_load = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);
    assign emit_last = ((emit_idx_reg + CntW'(1)) == emit_n_reg);
    assign emit_pv   = close_reg && (emit_idx_reg < npairs_reg);

    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_slots_reg     <= CntW'(8);
            fec_slots_reg      <= CntW'(4);
            restart_window_reg <= CfgW'(128);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                RegDataSlots:     data_slots_reg     <= cfg_data[CntW-1:0];
                RegFecSlots:      fec_slots_reg      <= cfg_data[CntW-1:0];
                RegRestartWindow: restart_window_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            open_valid_reg <= 1'b0;
            high_valid_reg <= 1'b0;
            rcv_reg        <= '0;
            good_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !emit_load)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (cnt_reg == '1)
                        state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    state_reg <= S_APPLY;
                end
                S_APPLY:
                begin
                    if (take_reg)
                    begin
                        open_valid_reg <= 1'b1;
                        high_valid_reg <= 1'b1;
                    end
                    rcv_reg   <= rcv_next;
                    good_reg  <= good_next;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (emit_load)
                    begin
                        out_valid_reg <= 1'b1;
                        if (emit_last)
                            state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            seq_reg    <= in_data.seq_num;
            ok_reg     <= in_data.packet_crc_ok;
            rem_reg    <= '0;
            cnt_reg    <= '0;
            di_reg     <= '0;
            fi_reg     <= '0;
            dmiss_reg  <= '0;
            fmiss_reg  <= '0;
            npairs_reg <= '0;
        end

        if (state_reg == S_DIV)
        begin
            seq_reg <= {seq_reg[SeqW-2:0], q_bit};
            rem_reg <= q_bit ? rem_sub[SlotW-1:0] : rem_sh[SlotW-1:0];
            cnt_reg <= cnt_reg + DivCntW'(1);
            if (dmiss_hit)
                dmiss_reg <= dmiss_reg + CntW'(1);
            if (fmiss_hit)
                fmiss_reg <= fmiss_reg + CntW'(1);
            if (walk_on)
            begin
                if (d_good)
                    di_reg <= di_reg + CntW'(1);
                else if (!rcv_reg[wf_pos])
                    fi_reg <= fi_reg + CntW'(1);
                else
                begin
                    pair_d_reg[npairs_reg[PairW-1:0]] <= di_reg[PairW-1:0];
                    pair_f_reg[npairs_reg[PairW-1:0]] <= fi_reg[PairW-1:0];
                    npairs_reg <= npairs_reg + CntW'(1);
                    di_reg     <= di_reg + CntW'(1);
                    fi_reg     <= fi_reg + CntW'(1);
                end
            end
        end

        if (state_reg == S_DECIDE)
        begin
            restart_reg <= restart_now;
            take_reg    <= (newer_now || restart_now) && ok_reg;
            close_reg   <= (newer_now || restart_now) && ok_reg && !restart_now
                           && open_valid_reg;
        end

        if (state_reg == S_APPLY)
        begin
            if (take_reg)
            begin
                open_block_reg <= seq_reg;
                high_block_reg <= seq_reg;
            end
            res_stored_reg <= store_now;
            res_cnum_reg   <= close_reg ? open_block_reg : '0;
            emit_n_reg     <= (close_reg && npairs_reg != '0) ? npairs_reg : CntW'(1);
            emit_idx_reg   <= '0;
        end

        if (emit_load)
        begin
            out_data_reg.block_closed        <= close_reg;
            out_data_reg.closed_block_number <= res_cnum_reg;
            out_data_reg.pair_valid          <= emit_pv;
            out_data_reg.erased_data_index   <= emit_pv ? pair_d_reg[emit_idx_reg[PairW-1:0]]
                                                        : '0;
            out_data_reg.fec_index           <= emit_pv ? pair_f_reg[emit_idx_reg[PairW-1:0]]
                                                        : '0;
            out_data_reg.data_missing_count  <= close_reg ? dmiss_reg : '0;
            out_data_reg.fec_missing_count   <= close_reg ? fmiss_reg : '0;
            out_data_reg.recon_failed        <= close_reg && (dmiss_reg > (eff_f - fmiss_reg));
            out_data_reg.restart_seen        <= restart_reg && ok_reg;
            out_data_reg.packet_stored       <= res_stored_reg;
            out_data_reg.last                <= emit_last;
            emit_idx_reg                     <= emit_idx_reg + CntW'(1);
        end
    end

    // ------------------------------------------------------------------
    `FBET_ASSERT_NXT(a_accept_starts_div, clk, rst_n, in_valid && in_ready,
        (state_reg == S_DIV) && !in_ready, "accepted packet did not start the divider")
    `FBET_ASSERT_IMP(a_pair_needs_close, clk, rst_n, out_valid && out_data.pair_valid,
        out_data.block_closed, "substitution pair without a closed block")
    `FBET_ASSERT_IMP(a_pairs_bounded, clk, rst_n, state_reg == S_EMIT,
        (npairs_reg <= CntW'(MaxKind)) && (emit_idx_reg < emit_n_reg),
        "emit index or pair count out of range")

endmodule

>>> tb/tb_fec_block_erasure_tracker.sv
// ----------------------------------------------------------------------------
// tb_fec_block_erasure_tracker
// Self-checking bench for the FEC block erasure tracker. A behavioral tracker
// predicts the reports for every packet that goes in. Reports are compared
// field by field in arrival order. Directed cases cover the layout, repairs,
// restarts and size saturation. Random traffic follows well-formed blocks
// with loss profiles and noise under random gaps; one test adds a long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_fec_block_erasure_tracker;
    import fbet_pkg::*;

    localparam int ResetDataSlots     = 8;
    localparam int ResetFecSlots      = 4;
    localparam int ResetRestartWindow = 128;
    localparam int RandomItems        = 500;
    localparam int LongHoldCycles     = 300;
    localparam int StallLimit         = 4000;
    localparam int EndSettle          = 64;

    localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;   // unmapped index

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    in_t                in_data;
    logic               out_valid;
    logic               out_ready;
    out_t               out_data;
    logic               cfg_we;
    logic [CfgIdxW-1:0] cfg_index;
    logic [CfgW-1:0]    cfg_data;

    // tracker state as the block should hold it
    logic [4:0]  data_slots_reg;
    logic [4:0]  fec_slots_reg;
    logic [15:0] restart_window_reg;
    logic        blk_open;
    logic [31:0] open_blk;
    logic        top_valid;
    logic [31:0] top_blk;
    logic [31:0] slot_rx;
    logic [31:0] slot_ok;

    out_t pending_reports[$];
    out_t want;

    int  error_count;
    int  packet_count;
    int  useful_count;
    int  report_count;
    int  close_count;
    int  pair_count;
    int  restart_count;
    int  failed_count;
    int  stored_count;
    int  idle_cycles;
    bit  tx_no_gap;
    bit  rx_no_gap;
    bit  long_hold_req;

    fec_block_erasure_tracker i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int eff_data_slots();
        int d;
        d = data_slots_reg;
        if (d < 1)
            d = 1;
        if (d > 16)
            d = 16;
        return d;
    endfunction

    // both kinds cap at 16, so the 32-slot buffer never overflows
    function automatic int eff_fec_slots();
        int f;
        f = fec_slots_reg;
        if (f > 16)
            f = 16;
        return f;
    endfunction

    function automatic logic slot_is_fec(input int p, input int d, input int f);
        int m;
        m = (d < f) ? d : f;
        if (p < 2 * m)
            return (p % 2) == 1;
        return f > d;
    endfunction

    function automatic void track_packet(input logic [31:0] seq, input logic ok);
        int          d, f, k, slot, di, fi, npairs, dmiss, fmiss, nres;
        int          dpos[16];
        int          fpos[16];
        int          pair_d[16];
        int          pair_f[16];
        logic [31:0] sz, blk, pos, cnum;
        logic        restart, closed, failed, stored;
        out_t        r;
        d       = eff_data_slots();
        f       = eff_fec_slots();
        sz      = 32'(d + f);
        blk     = seq / sz;
        pos     = seq % sz;
        npairs  = 0;
        dmiss   = 0;
        fmiss   = 0;
        closed  = 1'b0;
        failed  = 1'b0;
        stored  = 1'b0;
        cnum    = '0;
        restart = top_valid && ((33'(blk) + 33'(restart_window_reg)) < 33'(top_blk));
        if ((!top_valid || blk > top_blk || restart) && ok)
        begin
            if (restart)
            begin
                slot_rx  = '0;
                slot_ok  = '0;
                blk_open = 1'b0;
            end
            if (blk_open)
            begin
                closed = 1'b1;
                cnum   = open_blk;
                slot   = 0;
                for (k = 0; k < 16; k++)
                begin
                    if (k < d)
                    begin
                        dpos[k] = slot;
                        slot++;
                    end
                    if (k < f)
                    begin
                        fpos[k] = slot;
                        slot++;
                    end
                end
                for (k = 0; k < d; k++)
                    if (!slot_rx[dpos[k]])
                        dmiss++;
                for (k = 0; k < f; k++)
                    if (!slot_rx[fpos[k]])
                        fmiss++;
                // good data is skipped, absent FEC is skipped, else pair them up
                di = 0;
                fi = 0;
                while (di < d && fi < f)
                begin
                    if (slot_rx[dpos[di]] && slot_ok[dpos[di]])
                        di++;
                    else if (!slot_rx[fpos[fi]])
                        fi++;
                    else
                    begin
                        pair_d[npairs] = di;
                        pair_f[npairs] = fi;
                        npairs++;
                        di++;
                        fi++;
                    end
                end
                failed  = dmiss > f - fmiss;
                slot_rx = '0;
                slot_ok = '0;
            end
            blk_open  = 1'b1;
            open_blk  = blk;
            top_valid = 1'b1;
            top_blk   = blk;
        end
        if (blk_open && open_blk == blk && !slot_ok[pos])
        begin
            slot_rx[pos] = 1'b1;
            slot_ok[pos] = ok;
            stored       = 1'b1;
        end
        nres = (npairs > 0) ? npairs : 1;
        for (k = 0; k < nres; k++)
        begin
            r.block_closed        = closed;
            r.closed_block_number = cnum;
            r.pair_valid          = k < npairs;
            r.erased_data_index   = (k < npairs) ? 4'(pair_d[k]) : '0;
            r.fec_index           = (k < npairs) ? 4'(pair_f[k]) : '0;
            r.data_missing_count  = 5'(dmiss);
            r.fec_missing_count   = 5'(fmiss);
            r.recon_failed        = failed;
            r.restart_seen        = restart && ok;
            r.packet_stored       = stored;
            r.last                = (k == nres - 1);
            pending_reports.push_back(r);
        end
        packet_count++;
        if (stored || closed || (restart && ok))
            useful_count++;
        close_count   += closed;
        pair_count    += npairs;
        restart_count += (restart && ok);
        failed_count  += failed;
        stored_count  += stored;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] got_val);
        if (got_val !== exp_val)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val,
                     got_val);
            error_count++;
        end
    endfunction

    // one output transfer per rising edge at most
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            report_count++;
            if (pending_reports.size() == 0)
            begin
                $display("%0t: report with nothing expected, got %h", $time, out_data);
                error_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("block_closed", 32'(want.block_closed),
                            32'(out_data.block_closed));
                check_field("closed_block_number", want.closed_block_number,
                            out_data.closed_block_number);
                check_field("pair_valid", 32'(want.pair_valid), 32'(out_data.pair_valid));
                check_field("erased_data_index", 32'(want.erased_data_index),
                            32'(out_data.erased_data_index));
                check_field("fec_index", 32'(want.fec_index), 32'(out_data.fec_index));
                check_field("data_missing_count", 32'(want.data_missing_count),
                            32'(out_data.data_missing_count));
                check_field("fec_missing_count", 32'(want.fec_missing_count),
                            32'(out_data.fec_missing_count));
                check_field("recon_failed", 32'(want.recon_failed),
                            32'(out_data.recon_failed));
                check_field("restart_seen", 32'(want.restart_seen),
                            32'(out_data.restart_seen));
                check_field("packet_stored", 32'(want.packet_stored),
                            32'(out_data.packet_stored));
                check_field("last", 32'(want.last), 32'(out_data.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit)
        begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // output side: random gaps, runs with none, and one long hold on request
    initial
    begin
        int gap;
        out_ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LongHoldCycles) @(posedge clk);
                long_hold_req = 1'b0;
            end
            else
            begin
                gap = rx_no_gap ? 0 : $urandom_range(0, 9);
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid === 1'b1 && out_ready === 1'b1));
        end
    end

    task automatic send_packet(input logic [31:0] seq, input logic ok);
        int gap;
        gap = tx_no_gap ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= in_t'{seq_num: seq, packet_crc_ok: ok};
        do
            @(posedge clk);
        while (!(in_valid === 1'b1 && in_ready === 1'b1));
        track_packet(seq, ok);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic configure(input logic [15:0] d_val, input logic [15:0] f_val,
                             input logic [15:0] w_val);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= RegDataSlots;
        cfg_data  <= d_val;
        @(posedge clk);
        data_slots_reg = d_val[4:0];
        cfg_index <= RegFecSlots;
        cfg_data  <= f_val;
        @(posedge clk);
        fec_slots_reg = f_val[4:0];
        cfg_index <= RegRestartWindow;
        cfg_data  <= w_val;
        @(posedge clk);
        restart_window_reg = w_val;
        // the unmapped index must change nothing
        cfg_index <= RegSpare;
        cfg_data  <= 16'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_noise(input int sz);
        longint unsigned stale;
        case ($urandom_range(0, 2))
            0: send_packet($urandom, 1'($urandom));
            1:
            begin
                stale = top_blk - ((top_blk > 3) ? $urandom_range(0, 3) : 0);
                send_packet(32'(stale * sz + $urandom_range(0, sz - 1)), 1'($urandom));
            end
            default: send_packet(32'($urandom_range(0, 255)), 1'($urandom));
        endcase
    endtask

    // whole blocks in slot order, each with its own loss profile
    task automatic run_flow(input int n_blocks);
        int              b, p, d, f, sz, prof;
        longint unsigned last_blk, cur;
        logic [31:0]     seq;
        logic            ok, keep, fec;
        d        = eff_data_slots();
        f        = eff_fec_slots();
        sz       = d + f;
        last_blk = (64'h1_0000_0000 / sz) - 1;
        case ($urandom_range(0, 4))
            0: cur = $urandom_range(0, 64);
            1: cur = last_blk - $urandom_range(0, n_blocks + 1);
            2: cur = $urandom % (last_blk + 1);
            default: cur = top_valid ? top_blk + 1 : 0;
        endcase
        for (b = 0; b < n_blocks; b++)
        begin
            if (cur > last_blk)
                cur = $urandom_range(0, 16);
            prof = $urandom_range(0, 4);
            for (p = 0; p < sz; p++)
            begin
                fec = slot_is_fec(p, d, f);
                case (prof)
                    0: keep = 1'b1;
                    1: keep = $urandom_range(0, 9) != 0;
                    2: keep = 1'($urandom_range(0, 1));
                    3: keep = fec;
                    default: keep = !fec && $urandom_range(0, 3) != 0;
                endcase
                if (keep)
                begin
                    seq = 32'(cur * sz + p);
                    ok  = $urandom_range(0, 7) != 0;
                    send_packet(seq, ok);
                    if (!ok && $urandom_range(0, 1) == 1)
                        send_packet(seq, 1'b1);
                end
                if ($urandom_range(0, 24) == 0)
                    send_noise(sz);
            end
            case ($urandom_range(0, 9))
                0: cur += $urandom_range(2, 4);
                1:
                begin
                    if (top_valid && top_blk > restart_window_reg + 1)
                        cur = $urandom_range(0, top_blk - restart_window_reg - 1);
                    else
                        cur += 1;
                end
                default: cur += 1;
            endcase
            // noise may have moved the newest block ahead; follow it unless a restart is due
            if (top_valid && cur <= top_blk && cur + restart_window_reg >= top_blk)
                cur = top_blk + 1;
        end
    endtask

    // reset sizes: 8 data + 4 FEC, interleaved d0 f0 d1 f1 d2 f2 d3 f3 d4..d7
    task automatic test_reset_layout();
        send_packet(32'd5, 1'b0);          // bad crc before any block: dropped
        send_packet(32'd0, 1'b1);
        send_packet(32'd1, 1'b1);
        send_packet(32'd2, 1'b0);
        send_packet(32'd2, 1'b1);          // retransmit repairs a bad slot
        send_packet(32'd0, 1'b0);          // slot already good
        send_packet(32'd4, 1'b0);
        send_packet(32'd7, 1'b1);
        send_packet(32'd3, 1'b0);          // bad FEC still counts as received
        send_packet(32'd24, 1'b1);         // closes block 0 with pairs
        send_packet(32'd13, 1'b1);         // older block inside the window
        send_packet(32'hFFFF_FFFF, 1'b0);  // newer block, bad crc
    endtask

    // raw sizes above 16 saturate; window 0 restarts on any drop
    task automatic test_saturated_sizes();
        configure(16'd31, 16'hFFFF, 16'd0);
        send_packet(32'hFFFF_FFFF, 1'b1);
        send_packet(32'hFFFF_FFE0, 1'b1);
        send_packet(32'h0000_0040, 1'b1);  // restart
        send_packet(32'h0000_0061, 1'b0);
        send_packet(32'h0000_0041, 1'b1);
        send_packet(32'h0000_0043, 1'b0);
        send_packet(32'h0000_0020, 1'b0);  // restart condition with bad crc
        send_packet(32'h0000_0062, 1'b1);
    endtask

    // zero sizes: one data slot per block, no FEC; old bits read with new layout
    task automatic test_single_slot_blocks();
        configure(16'd0, 16'd0, 16'hFFFF);
        send_packet(32'd100, 1'b1);
        send_packet(32'd100, 1'b1);
        send_packet(32'd101, 1'b1);
        send_packet(32'd7, 1'b1);
    endtask

    // output held off while packets keep coming, so the input backs up
    task automatic test_output_stall();
        configure(16'd8, 16'd8, 16'd128);
        tx_no_gap     = 1'b1;
        long_hold_req = 1'b1;
        run_flow(2);
        tx_no_gap = 1'b0;
    endtask

    task automatic test_random_traffic();
        int          phase, d_raw, f_raw, sz;
        logic [15:0] d_val, f_val, w_val;
        phase = 0;
        while (useful_count < RandomItems)
        begin
            d_raw = $urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(1, 16);
            f_raw = $urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(0, 16);
            case ($urandom_range(0, 4))
                0: w_val = 16'd0;
                1: w_val = 16'd1;
                2: w_val = 16'($urandom_range(2, 8));
                3: w_val = 16'hFFFF;
                default: w_val = 16'($urandom);
            endcase
            case (phase)
                0:
                begin
                    d_raw = 16;
                    f_raw = 16;
                end
                1:
                begin
                    d_raw = 1;
                    f_raw = 0;
                end
                2:
                begin
                    d_raw = 31;
                    f_raw = 31;
                    w_val = 16'hFFFF;
                end
                3:
                begin
                    d_raw = 16;
                    f_raw = 0;
                end
                4:
                begin
                    d_raw = 1;
                    f_raw = 16;
                end
                default: ;
            endcase
            d_val = 16'(d_raw);
            f_val = 16'(f_raw);
            if ($urandom_range(0, 3) == 0)
                d_val[15:5] = 11'($urandom);
            if ($urandom_range(0, 3) == 0)
                f_val[15:5] = 11'($urandom);
            configure(d_val, f_val, w_val);
            tx_no_gap = $urandom_range(0, 3) == 0;
            rx_no_gap = $urandom_range(0, 3) == 0;
            sz = eff_data_slots() + eff_fec_slots();
            run_flow(2 + 48 / sz);
            phase++;
        end
        tx_no_gap = 1'b0;
        rx_no_gap = 1'b0;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= RegDataSlots;
        cfg_data  <= '0;
        data_slots_reg     = 5'(ResetDataSlots);
        fec_slots_reg      = 5'(ResetFecSlots);
        restart_window_reg = 16'(ResetRestartWindow);
        blk_open      = 1'b0;
        open_blk      = '0;
        top_valid     = 1'b0;
        top_blk       = '0;
        slot_rx       = '0;
        slot_ok       = '0;
        error_count   = 0;
        packet_count  = 0;
        useful_count  = 0;
        report_count  = 0;
        close_count   = 0;
        pair_count    = 0;
        restart_count = 0;
        failed_count  = 0;
        stored_count  = 0;
        idle_cycles   = 0;
        tx_no_gap     = 1'b0;
        rx_no_gap     = 1'b0;
        long_hold_req = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_layout();
        test_saturated_sizes();
        test_single_slot_blocks();
        test_output_stall();
        test_random_traffic();

        wait_idle();
        repeat (EndSettle) @(posedge clk);
        $display("Run covered %0d packets and %0d reports: %0d stored, %0d blocks closed",
                 packet_count, report_count, stored_count, close_count);
        $display("with %0d substitution pairs, %0d failed recoveries and %0d restarts.",
                 pair_count, failed_count, restart_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
